[design/jtag_tap_scan_sequencer_assert.svh]
// Assertion macros for the JTAG TAP scan sequencer.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef JTAG_TAP_SCAN_SEQUENCER_ASSERT_SVH
`define JTAG_TAP_SCAN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JTSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JTSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/jtss_pkg.sv]
// Package for the JTAG TAP scan sequencer: field widths, function codes,
// command kinds and TMS patterns. No dependencies.
package jtss_pkg;

    localparam int FUNC_W  = 3;
    localparam int LEN_W   = 6;
    localparam int WORD_W  = 32;
    localparam int TICKS_W = 16;
    localparam int KIND_W  = 3;

    localparam int DEF_MAX_SCAN_BITS = 32;
    localparam int DEF_RESET_PULSES  = 10;

    // Function codes carried on the func field
    localparam logic [FUNC_W-1:0] FUNC_RESET    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_IR_SCAN  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DR_WRITE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DR_READ  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RUN_IDLE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DR_PAUSE = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 3'd0,
        KIND_RESET    = 3'd1,
        KIND_IR       = 3'd2,
        KIND_DR_WRITE = 3'd3,
        KIND_DR_READ  = 3'd4,
        KIND_IDLE     = 3'd5,
        KIND_PAUSE    = 3'd6
    } cmd_kind_t;

    // TMS patterns, bit i is pulse i
    localparam int IR_HEAD_LEN = 4;
    localparam int DR_HEAD_LEN = 3;
    localparam int PAUSE_LEN   = 7;
    localparam logic [IR_HEAD_LEN-1:0] IR_HEAD_TMS = 4'b0011;
    localparam logic [DR_HEAD_LEN-1:0] DR_HEAD_TMS = 3'b001;
    localparam logic [PAUSE_LEN-1:0]   PAUSE_TMS   = 7'b0110101;

endpackage

[design/jtag_tap_scan_sequencer.sv]
// JTAG TAP master scan sequencer, single module.
// Depends on jtss_pkg and jtag_tap_scan_sequencer_assert.svh.
//
// Command items (reset, IR scan, DR write, DR read, run idle, DR pause) load
// a TAP sequence and give no result; each tick item then gives one result
// with the TMS and TDI levels for one TCK pulse. Scans go LSB first, TMS
// rises on the last shift bit, then an update pulse and an idle pulse close
// the scan. A DR read packs the TDO level of each shift tick into the
// capture word, shown on the done tick. Commands that arrive while a
// sequence runs are dropped, as is func 7. The state update is one short
// pass from the state registers to the result register, so an item enters
// on every cycle in which the result register is empty or is being taken.
// in_stall rises only while a result waits under out_stall. A tick with no
// command loaded returns clock_pulse 0, TMS 0 and TDI 1.
module jtag_tap_scan_sequencer #(
    parameter int MAX_SCAN_BITS = jtss_pkg::DEF_MAX_SCAN_BITS,
    parameter int RESET_PULSES  = jtss_pkg::DEF_RESET_PULSES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [jtss_pkg::FUNC_W-1:0]  func,
    input  logic [jtss_pkg::LEN_W-1:0]   scan_length,
    input  logic [jtss_pkg::WORD_W-1:0]  shift_word,
    input  logic [jtss_pkg::TICKS_W-1:0] idle_ticks,
    input  logic                         tdo_pin,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         tms_level,
    output logic                         tdi_level,
    output logic                         clock_pulse,
    output logic                         busy_res,
    output logic                         done_res,
    output logic [jtss_pkg::WORD_W-1:0]  capture_word
);
    import jtss_pkg::*;
    `include "jtag_tap_scan_sequencer_assert.svh"

    localparam int BitsW   = $clog2(MAX_SCAN_BITS + 1);
    localparam int StepMax = (RESET_PULSES + 2 > 8) ? RESET_PULSES + 2 : 8;
    localparam int StepW   = $clog2(StepMax);
    localparam int PosW    = LEN_W;
    localparam int IdxW    = $clog2(WORD_W);

    // Sequencer state
    cmd_kind_t            kind_reg, kind_next;
    logic [StepW-1:0]     step_reg, step_next;
    logic [BitsW-1:0]     bits_reg, bits_next;
    logic [WORD_W-1:0]    out_shift_reg, out_shift_next;
    logic [WORD_W-1:0]    in_shift_reg, in_shift_next;
    logic [TICKS_W-1:0]   ticks_reg, ticks_next;
    logic [PosW-1:0]      pos_reg, pos_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic                 tms_reg, tdi_reg, pulse_reg, busy_reg, done_reg;
    logic [WORD_W-1:0]    cap_reg;

    logic                 in_accept;
    logic                 is_tick;
    logic                 is_cmd;
    logic [BitsW-1:0]     load_len;

    // Levels for the current tick, from state alone
    logic                 tms_o, tdi_o, done_o;
    logic [WORD_W-1:0]    cap_o;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign is_tick   = (func == FUNC_TICK);
    assign is_cmd    = (func == FUNC_RESET) || (func == FUNC_IR_SCAN) ||
                       (func == FUNC_DR_WRITE) || (func == FUNC_DR_READ) ||
                       (func == FUNC_RUN_IDLE) || (func == FUNC_DR_PAUSE);

    // Clamp the scan length into 1..MAX_SCAN_BITS
    always_comb
    begin
        if (scan_length == '0)
        begin
            load_len = BitsW'(1);
        end
        else if (int'(scan_length) > MAX_SCAN_BITS)
        begin
            load_len = BitsW'(MAX_SCAN_BITS);
        end
        else
        begin
            load_len = BitsW'(scan_length);
        end
    end

    // Output decode: TMS, TDI and done for a tick in the current state
    always_comb
    begin
        tms_o  = 1'b0;
        tdi_o  = 1'b1;
        done_o = 1'b0;
        cap_o  = '0;
        case (kind_reg)
            KIND_RESET:
            begin
                if (int'(step_reg) < RESET_PULSES + 1)
                begin
                    tms_o = 1'b1;
                end
                else
                begin
                    done_o = 1'b1;
                end
            end
            KIND_IDLE:
            begin
                done_o = (ticks_reg == TICKS_W'(1));
            end
            KIND_PAUSE:
            begin
                tms_o  = PAUSE_TMS[step_reg[2:0]];
                done_o = (int'(step_reg) >= PAUSE_LEN - 1);
            end
            KIND_IR:
            begin
                if (int'(step_reg) < IR_HEAD_LEN)
                begin
                    tms_o = IR_HEAD_TMS[step_reg[1:0]];
                end
                else if (bits_reg != '0)
                begin
                    tdi_o = out_shift_reg[0];
                    tms_o = (bits_reg == BitsW'(1));
                end
                else if (int'(step_reg) == IR_HEAD_LEN)
                begin
                    tms_o = 1'b1;
                end
                else
                begin
                    done_o = 1'b1;
                end
            end
            KIND_DR_WRITE, KIND_DR_READ:
            begin
                if (int'(step_reg) < DR_HEAD_LEN)
                begin
                    tms_o = DR_HEAD_TMS[step_reg[1:0]];
                end
                else if (bits_reg != '0)
                begin
                    tdi_o = (kind_reg == KIND_DR_READ) ? 1'b0 : out_shift_reg[0];
                    tms_o = (bits_reg == BitsW'(1));
                end
                else if (int'(step_reg) == DR_HEAD_LEN)
                begin
                    tms_o = 1'b1;
                end
                else
                begin
                    done_o = 1'b1;
                    cap_o  = (kind_reg == KIND_DR_READ) ? in_shift_reg : '0;
                end
            end
            default:
            begin
                tms_o = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        kind_next      = kind_reg;
        step_next      = step_reg;
        bits_next      = bits_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;
        ticks_next     = ticks_reg;
        pos_next       = pos_reg;

        if (in_accept && is_cmd && (kind_reg == KIND_NONE))
        begin
            // Idle state holds all-zero fields, so only load what differs
            case (func)
                FUNC_RESET:
                begin
                    kind_next = KIND_RESET;
                end
                FUNC_IR_SCAN:
                begin
                    kind_next      = KIND_IR;
                    bits_next      = load_len;
                    out_shift_next = shift_word;
                end
                FUNC_DR_WRITE:
                begin
                    kind_next      = KIND_DR_WRITE;
                    bits_next      = load_len;
                    out_shift_next = shift_word;
                end
                FUNC_DR_READ:
                begin
                    kind_next = KIND_DR_READ;
                    bits_next = load_len;
                end
                FUNC_RUN_IDLE:
                begin
                    if (idle_ticks != '0)
                    begin
                        kind_next  = KIND_IDLE;
                        ticks_next = idle_ticks;
                    end
                end
                FUNC_DR_PAUSE:
                begin
                    kind_next = KIND_PAUSE;
                end
                default:
                begin
                    kind_next = kind_reg;
                end
            endcase
        end
        else if (in_accept && is_tick && (kind_reg != KIND_NONE))
        begin
            if (done_o)
            begin
                kind_next      = KIND_NONE;
                step_next      = '0;
                bits_next      = '0;
                out_shift_next = '0;
                in_shift_next  = '0;
                ticks_next     = '0;
                pos_next       = '0;
            end
            else
            begin
                case (kind_reg)
                    KIND_IDLE:
                    begin
                        ticks_next = ticks_reg - TICKS_W'(1);
                    end
                    KIND_IR, KIND_DR_WRITE, KIND_DR_READ:
                    begin
                        // Shift phase advances the bit pointer, not the step
                        if ((int'(step_reg) >= ((kind_reg == KIND_IR) ? IR_HEAD_LEN
                                                                       : DR_HEAD_LEN))
                            && (bits_reg != '0))
                        begin
                            out_shift_next = out_shift_reg >> 1;
                            bits_next      = bits_reg - BitsW'(1);
                            pos_next       = pos_reg + PosW'(1);
                            if ((kind_reg == KIND_DR_READ) && (int'(pos_reg) < WORD_W))
                            begin
                                in_shift_next = in_shift_reg |
                                    (WORD_W'(tdo_pin) << pos_reg[IdxW-1:0]);
                            end
                        end
                        else
                        begin
                            step_next = step_reg + StepW'(1);
                        end
                    end
                    default:
                    begin
                        step_next = step_reg + StepW'(1);
                    end
                endcase
            end
        end
    end

    // Result register: load on a tick transfer, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept && is_tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_NONE;
            step_reg      <= '0;
            bits_reg      <= '0;
            out_shift_reg <= '0;
            in_shift_reg  <= '0;
            ticks_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            step_reg      <= step_next;
            bits_reg      <= bits_next;
            out_shift_reg <= out_shift_next;
            in_shift_reg  <= in_shift_next;
            ticks_reg     <= ticks_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload holds no reset
    always_ff @(posedge clk)
    begin
        if (in_accept && is_tick)
        begin
            if (kind_reg == KIND_NONE)
            begin
                tms_reg   <= 1'b0;
                tdi_reg   <= 1'b1;
                pulse_reg <= 1'b0;
                busy_reg  <= 1'b0;
                done_reg  <= 1'b0;
                cap_reg   <= '0;
            end
            else
            begin
                tms_reg   <= tms_o;
                tdi_reg   <= tdi_o;
                pulse_reg <= 1'b1;
                busy_reg  <= 1'b1;
                done_reg  <= done_o;
                cap_reg   <= cap_o;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign tms_level    = tms_reg;
    assign tdi_level    = tdi_reg;
    assign clock_pulse  = pulse_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign capture_word = cap_reg;

    // Checks on the sequencer
    `JTSS_ASSERT_NOW(a_idle_state_clear, kind_reg == KIND_NONE,
        (step_reg == '0) && (bits_reg == '0) && (in_shift_reg == '0) &&
        (ticks_reg == '0) && (pos_reg == '0), "idle state holds leftover fields")
    `JTSS_ASSERT_NOW(a_done_implies_pulse, out_valid && done_res,
        busy_res && clock_pulse, "done result without a TCK pulse")
    `JTSS_ASSERT_NEXT(a_done_clears_kind, in_accept && is_tick && (kind_reg != KIND_NONE) &&
        done_o, kind_reg == KIND_NONE, "finished command did not return to idle")
    `JTSS_ASSERT_NEXT(a_busy_drops_cmd, in_accept && is_cmd && (kind_reg != KIND_NONE),
        $stable(kind_reg) && $stable(bits_reg), "command taken while busy")

endmodule
